[hdl/uart_rx_tx_ring_buffers_unit_macros.svh]
// Assertion macros shared by the UART ring buffer modules.
// Expects clk and rst_n in the scope of each use.
`ifndef UART_RX_TX_RING_BUFFERS_UNIT_MACROS_SVH
`define UART_RX_TX_RING_BUFFERS_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define URTRB_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define URTRB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/urtrb_pkg.sv]
// Package for the UART receive/transmit ring buffer unit.
// Holds depths, derived widths, opcodes, status codes and the command struct.
`default_nettype none

package urtrb_pkg;

    localparam int RX_DEPTH = 64;
    localparam int TX_DEPTH = 64;
    localparam int RX_AW    = $clog2(RX_DEPTH);
    localparam int TX_AW    = $clog2(TX_DEPTH);
    localparam int RX_CW    = $clog2(RX_DEPTH + 1);
    localparam int TX_CW    = $clog2(TX_DEPTH + 1);
    localparam int LEVEL_W  = 7;

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_RX_FULL  = 3'd1;
    localparam logic [2:0] ST_NUL_DROP = 3'd2;
    localparam logic [2:0] ST_TX_FULL  = 3'd3;
    localparam logic [2:0] ST_RX_EMPTY = 3'd4;
    localparam logic [2:0] ST_TX_IDLE  = 3'd5;

    localparam logic REG_CR_TO_LF = 1'b0;
    localparam logic REG_DROP_NUL = 1'b1;

    typedef enum logic [1:0] {
        OP_RX_BYTE    = 2'd0,
        OP_TX_EVENT   = 2'd1,
        OP_HOST_WRITE = 2'd2,
        OP_HOST_READ  = 2'd3
    } op_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic finish;
    } dp_cmd_t;

endpackage

`default_nettype wire

[hdl/urtrb_ctrl.sv]
// Controller state machine for the UART ring buffer unit.
// Depends on urtrb_pkg; drives the datapath command struct, busy and done.
`default_nettype none

`include "uart_rx_tx_ring_buffers_unit_macros.svh"

module urtrb_ctrl
    import urtrb_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    output dp_cmd_t      cmd,
    output logic         busy,
    output logic         done
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   busy_next;
    logic   done_reg;
    logic   done_next;

    always_comb
    begin
        state_next = state_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                    busy_next  = 1'b1;
                end
            end
            S_EXEC:
            begin
                state_next = S_RESP;
                done_next  = 1'b1;
            end
            S_RESP:
            begin
                state_next = S_IDLE;
                busy_next  = 1'b0;
            end
            default:
            begin
                state_next = S_IDLE;
                busy_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    assign cmd.load   = start && !busy_reg;
    assign cmd.exec   = (state_reg == S_EXEC);
    assign cmd.finish = (state_reg == S_RESP);
    assign busy       = busy_reg;
    assign done       = done_reg;

    `URTRB_ASSERT_SAME(a_done_while_busy, done_reg, busy_reg, "done outside a busy window")
    `URTRB_ASSERT_NEXT(a_accept_sets_busy, start && !busy_reg, busy_reg && !done_reg,
                       "accepted request did not raise busy")
    `URTRB_ASSERT_NEXT(a_done_frees, done_reg, !busy_reg && !done_reg,
                       "busy held after result strobe")

endmodule

`default_nettype wire

[hdl/urtrb_dp.sv]
// Datapath of the UART ring buffer unit: both rings, counters, config and result.
// Depends on urtrb_pkg; sequenced by urtrb_ctrl through dp_cmd_t.
`default_nettype none

`include "uart_rx_tx_ring_buffers_unit_macros.svh"

module urtrb_dp
    import urtrb_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire dp_cmd_t             cmd,
    input  wire logic [1:0]          opcode,
    input  wire logic [7:0]          data_byte,
    input  wire logic                cfg_we,
    input  wire logic                cfg_index,
    input  wire logic                cfg_data,
    output logic [7:0]               out_byte,
    output logic                     out_valid,
    output logic [2:0]               status,
    output logic [LEVEL_W-1:0]       rx_level,
    output logic [LEVEL_W-1:0]       tx_level,
    output logic                     line_ready,
    output logic                     tx_irq_on
);

    logic [7:0]      rx_mem [RX_DEPTH];
    logic [7:0]      tx_mem [TX_DEPTH];

    op_t             op_reg;
    logic [7:0]      byte_reg;
    logic [7:0]      rx_rd_reg;
    logic [7:0]      tx_rd_reg;

    logic            cr_en_reg;
    logic            nul_en_reg;
    logic [RX_AW-1:0] rx_head_reg, rx_head_next;
    logic [RX_AW-1:0] rx_tail_reg, rx_tail_next;
    logic [RX_CW-1:0] rx_fill_reg, rx_fill_next;
    logic [TX_AW-1:0] tx_head_reg, tx_head_next;
    logic [TX_AW-1:0] tx_tail_reg, tx_tail_next;
    logic [TX_CW-1:0] tx_fill_reg, tx_fill_next;
    logic [RX_CW-1:0] tally_reg, tally_next;
    logic            irq_reg, irq_next;
    logic [2:0]      status_reg, status_next;
    logic            ov_reg, ov_next;
    logic            pop_rx_reg, pop_rx_next;

    logic            rx_we;
    logic            tx_we;
    logic            rx_re;
    logic            tx_re;
    logic [7:0]      conv_byte;
    logic [RX_CW-1:0] tally_eff;

    assign conv_byte = (cr_en_reg && byte_reg == CH_CR) ? CH_LF : byte_reg;

    // Line feed popped by the last host read leaves the tally when the result shows.
    assign tally_eff = (pop_rx_reg && rx_rd_reg == CH_LF && tally_reg != '0)
                       ? tally_reg - RX_CW'(1) : tally_reg;

    always_comb
    begin
        rx_head_next = rx_head_reg;
        rx_tail_next = rx_tail_reg;
        rx_fill_next = rx_fill_reg;
        tx_head_next = tx_head_reg;
        tx_tail_next = tx_tail_reg;
        tx_fill_next = tx_fill_reg;
        tally_next   = tally_reg;
        irq_next     = irq_reg;
        status_next  = status_reg;
        ov_next      = ov_reg;
        pop_rx_next  = pop_rx_reg;
        rx_we        = 1'b0;
        tx_we        = 1'b0;
        rx_re        = 1'b0;
        tx_re        = 1'b0;
        if (cmd.exec)
        begin
            status_next = ST_OK;
            ov_next     = 1'b0;
            pop_rx_next = 1'b0;
            case (op_reg)
                OP_RX_BYTE:
                begin
                    if (nul_en_reg && byte_reg == CH_NUL)
                        status_next = ST_NUL_DROP;
                    else if (rx_fill_reg == RX_CW'(RX_DEPTH))
                        status_next = ST_RX_FULL;
                    else
                    begin
                        rx_we        = 1'b1;
                        rx_head_next = (rx_head_reg == RX_AW'(RX_DEPTH - 1))
                                       ? '0 : rx_head_reg + RX_AW'(1);
                        rx_fill_next = rx_fill_reg + RX_CW'(1);
                        if (conv_byte == CH_LF)
                            tally_next = tally_reg + RX_CW'(1);
                    end
                end
                OP_TX_EVENT:
                begin
                    if (tx_fill_reg != '0)
                    begin
                        tx_re        = 1'b1;
                        ov_next      = 1'b1;
                        tx_tail_next = (tx_tail_reg == TX_AW'(TX_DEPTH - 1))
                                       ? '0 : tx_tail_reg + TX_AW'(1);
                        tx_fill_next = tx_fill_reg - TX_CW'(1);
                    end
                    else
                    begin
                        irq_next    = 1'b0;
                        status_next = ST_TX_IDLE;
                    end
                end
                OP_HOST_WRITE:
                begin
                    if (tx_fill_reg == TX_CW'(TX_DEPTH))
                        status_next = ST_TX_FULL;
                    else
                    begin
                        tx_we        = 1'b1;
                        tx_head_next = (tx_head_reg == TX_AW'(TX_DEPTH - 1))
                                       ? '0 : tx_head_reg + TX_AW'(1);
                        tx_fill_next = tx_fill_reg + TX_CW'(1);
                        irq_next     = 1'b1;
                    end
                end
                OP_HOST_READ:
                begin
                    if (rx_fill_reg == '0)
                        status_next = ST_RX_EMPTY;
                    else
                    begin
                        rx_re        = 1'b1;
                        ov_next      = 1'b1;
                        pop_rx_next  = 1'b1;
                        rx_tail_next = (rx_tail_reg == RX_AW'(RX_DEPTH - 1))
                                       ? '0 : rx_tail_reg + RX_AW'(1);
                        rx_fill_next = rx_fill_reg - RX_CW'(1);
                    end
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
        if (cmd.finish)
        begin
            tally_next  = tally_eff;
            pop_rx_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_we)
            rx_mem[rx_head_reg] <= conv_byte;
        if (rx_re)
            rx_rd_reg <= rx_mem[rx_tail_reg];
    end

    always_ff @(posedge clk)
    begin
        if (tx_we)
            tx_mem[tx_head_reg] <= byte_reg;
        if (tx_re)
            tx_rd_reg <= tx_mem[tx_tail_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= op_t'(opcode);
            byte_reg <= data_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cr_en_reg   <= 1'b1;
            nul_en_reg  <= 1'b1;
            rx_head_reg <= '0;
            rx_tail_reg <= '0;
            rx_fill_reg <= '0;
            tx_head_reg <= '0;
            tx_tail_reg <= '0;
            tx_fill_reg <= '0;
            tally_reg   <= '0;
            irq_reg     <= 1'b0;
            status_reg  <= ST_OK;
            ov_reg      <= 1'b0;
            pop_rx_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == REG_CR_TO_LF)
                cr_en_reg <= cfg_data;
            if (cfg_we && cfg_index == REG_DROP_NUL)
                nul_en_reg <= cfg_data;
            rx_head_reg <= rx_head_next;
            rx_tail_reg <= rx_tail_next;
            rx_fill_reg <= rx_fill_next;
            tx_head_reg <= tx_head_next;
            tx_tail_reg <= tx_tail_next;
            tx_fill_reg <= tx_fill_next;
            tally_reg   <= tally_next;
            irq_reg     <= irq_next;
            status_reg  <= status_next;
            ov_reg      <= ov_next;
            pop_rx_reg  <= pop_rx_next;
        end
    end

    always_comb
    begin
        if (!ov_reg)
            out_byte = 8'h00;
        else if (op_reg == OP_HOST_READ)
            out_byte = rx_rd_reg;
        else
            out_byte = tx_rd_reg;
    end

    assign out_valid  = ov_reg;
    assign status     = status_reg;
    assign rx_level   = LEVEL_W'(rx_fill_reg);
    assign tx_level   = LEVEL_W'(tx_fill_reg);
    assign line_ready = (tally_eff != '0);
    assign tx_irq_on  = irq_reg;

    `URTRB_ASSERT_SAME(a_rx_fill_bound, 1'b1, rx_fill_reg <= RX_CW'(RX_DEPTH),
                       "receive fill beyond depth")
    `URTRB_ASSERT_SAME(a_tx_fill_bound, 1'b1, tx_fill_reg <= TX_CW'(TX_DEPTH),
                       "transmit fill beyond depth")
    `URTRB_ASSERT_SAME(a_pop_status_ok, ov_reg, status_reg == ST_OK,
                       "popped byte with error status")

endmodule

`default_nettype wire

[hdl/uart_rx_tx_ring_buffers_unit.sv]
// UART receive/transmit ring buffer unit, top level.
// The result is registered and is up in the same cycle as done.
// A new request is not accepted while busy is high; the registered ring read and commit set the pace.
// busy is high from acceptance through the done cycle; the receiver cannot stall results.
// Reset (rst_n low, asynchronous): rings empty, tally and irq enable cleared,
// both option registers set to 1; ring contents are not cleared.
`default_nettype none

module uart_rx_tx_ring_buffers_unit
    import urtrb_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    output logic                    done,
    input  wire logic [1:0]         opcode,
    input  wire logic [7:0]         data_byte,
    input  wire logic               cfg_we,
    input  wire logic               cfg_index,
    input  wire logic               cfg_data,
    output logic [7:0]              out_byte,
    output logic                    out_valid,
    output logic [2:0]              status,
    output logic [LEVEL_W-1:0]      rx_level,
    output logic [LEVEL_W-1:0]      tx_level,
    output logic                    line_ready,
    output logic                    tx_irq_on
);

    dp_cmd_t cmd;

    urtrb_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    urtrb_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .opcode     (opcode),
        .data_byte  (data_byte),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .out_byte   (out_byte),
        .out_valid  (out_valid),
        .status     (status),
        .rx_level   (rx_level),
        .tx_level   (tx_level),
        .line_ready (line_ready),
        .tx_irq_on  (tx_irq_on)
    );

endmodule

`default_nettype wire
